>>> src/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer package
// Shared types and constants for the deframer front end, queue and decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// Framing bytes.
	localparam logic [7:0] START_BYTE = 8'h5A;
	localparam logic [7:0] END_BYTE   = 8'h69;

	// Frame type bytes, stored in slots 1 to 3.
	localparam logic [7:0] TYPE_U   = 8'h55;
	localparam logic [7:0] TYPE_S   = 8'h53;
	localparam logic [7:0] SEL_CELL = 8'h43;
	localparam logic [7:0] SEL_TEMP = 8'h4E;
	localparam logic [7:0] SEL_CURR = 8'h49;

	// Record kinds on the output.
	localparam logic [1:0] KIND_VOLT = 2'd0;
	localparam logic [1:0] KIND_TEMP = 2'd1;
	localparam logic [1:0] KIND_CURR = 2'd2;

	// Index of the last record that one frame can give, so at most 30 records leave one frame.
	localparam logic [4:0] LAST_RECORD_IDX = 5'd29;

	// Divide by 100 as (v * 83887) >> 23, exact for every 16-bit v.
	localparam logic [16:0] DIV100_MUL   = 17'd83887;
	localparam int          DIV100_SHIFT = 23;

	// Command codes passed from front end to decoder.
	localparam logic CMD_STORE  = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// Queue depth between front end and decoder.
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic       op;
		logic [7:0] addr;
		logic [7:0] data;
	} cmd_t;

endpackage

>>> src/sfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer front end
// Hunts for the start byte, counts and checks frame bytes, issues commands.
// ----------------------------------------------------------------------------
module sfd_front import sfd_pkg::*; #(
	parameter int FRAME_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	localparam logic [1:0] PH_HUNT  = 2'd0;
	localparam logic [1:0] PH_STORE = 2'd1;
	localparam logic [1:0] PH_END   = 2'd2;
	localparam logic [8:0] FB_LIM   = 9'(FRAME_BYTES);

	logic [1:0] phase_q;
	logic [7:0] cnt_q;
	logic [7:0] xor_q;
	logic [7:0] len_q;
	logic       acc;
	logic [7:0] len_now;
	logic [8:0] cnt_nxt;

	assign in_ready = cmd_ready;
	assign acc      = in_valid && in_ready;
	assign len_now  = (cnt_q == 8'd0) ? rx_byte : len_q;
	assign cnt_nxt  = {1'b0, cnt_q} + 9'd1;

	always_comb begin
		cmd.op    = (phase_q == PH_END) ? CMD_DECODE : CMD_STORE;
		cmd.addr  = cnt_q;
		cmd.data  = rx_byte;
		cmd_valid = acc && ((phase_q == PH_STORE) ||
			(phase_q == PH_END && rx_byte == END_BYTE && xor_q == 8'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			xor_q   <= '0;
			len_q   <= '0;
		end else if (acc) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == START_BYTE) begin
						phase_q <= PH_STORE;
						cnt_q   <= '0;
						xor_q   <= '0;
					end
				end
				PH_STORE: begin
					xor_q <= xor_q ^ rx_byte;
					cnt_q <= cnt_nxt[7:0];
					if (cnt_q == 8'd0) begin
						len_q <= rx_byte;
					end
					if (cnt_nxt >= {1'b0, len_now}) begin
						phase_q <= PH_END;
					end else if (cnt_nxt >= FB_LIM) begin
						phase_q <= PH_HUNT;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

endmodule

>>> src/sfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer command queue
// Small first-in first-out buffer between the front end and the decoder.
// ----------------------------------------------------------------------------
module sfd_queue import sfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (fill_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + CW'(1);
				2'b01:   fill_q <= fill_q - CW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> src/sfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer decoder back end
// Holds the frame store and walks it to produce voltage, temperature and
// current records.
// ----------------------------------------------------------------------------
module sfd_back import sfd_pkg::*; #(
	parameter int FRAME_BYTES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  cmd_t               cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         record_kind,
	output logic [4:0]         record_index,
	output logic signed [28:0] record_value,
	output logic               last_record
);

	localparam int AW = $clog2(FRAME_BYTES);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_CALC  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [7:0]  mem_q [FRAME_BYTES];
	logic [7:0]  rdata_q;
	logic [2:0]  state_q;
	logic [7:0]  rd_addr_q;
	logic [2:0]  left_q;
	logic        cap_s1;
	logic [31:0] sh_q;
	logic [32:0] prod_q;
	logic [7:0]  pos_q;
	logic [4:0]  n_q;
	logic [1:0]  kind_q;
	logic        last_q;
	logic [28:0] val_q;
	logic [7:0]  hdr_len_q;
	logic [7:0]  hdr_t1_q;
	logic [7:0]  hdr_t2_q;
	logic [7:0]  hdr_sel_q;
	logic        take;
	logic        wr_en;
	logic [27:0] mag;

	assign cmd_ready    = (state_q == ST_IDLE);
	assign take         = cmd_valid && cmd_ready;
	assign wr_en        = take && (cmd.op == CMD_STORE);
	assign mag          = sh_q[27:0];
	assign out_valid    = (state_q == ST_OUT);
	assign record_kind  = kind_q;
	assign record_index = n_q;
	assign record_value = val_q;
	assign last_record  = last_q;

	// Frame store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[cmd.addr[AW-1:0]] <= cmd.data;
		end
		rdata_q <= mem_q[rd_addr_q[AW-1:0]];
	end

	// Header copy of slots 0 to 3, kept in step with the store.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (cmd.addr)
				8'd0:    hdr_len_q <= cmd.data;
				8'd1:    hdr_t1_q  <= cmd.data;
				8'd2:    hdr_t2_q  <= cmd.data;
				8'd3:    hdr_sel_q <= cmd.data;
				default: hdr_len_q <= hdr_len_q;
			endcase
		end
	end

	// Read bytes shift in from the top, so the earliest byte ends lowest.
	always_ff @(posedge clk) begin
		if (cap_s1) begin
			sh_q <= {rdata_q, sh_q[31:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cap_s1    <= 1'b0;
			rd_addr_q <= '0;
			left_q    <= '0;
			pos_q     <= '0;
			n_q       <= '0;
			kind_q    <= KIND_VOLT;
			last_q    <= 1'b0;
			val_q     <= '0;
			prod_q    <= '0;
		end else begin
			cap_s1 <= (state_q == ST_READ);
			case (state_q)
				ST_IDLE: begin
					if (take && cmd.op == CMD_DECODE &&
						hdr_t1_q == TYPE_U && hdr_t2_q == TYPE_S) begin
						pos_q     <= 8'd4;
						n_q       <= '0;
						rd_addr_q <= 8'd4;
						if (hdr_sel_q inside {SEL_CELL, SEL_TEMP}) begin
							kind_q <= (hdr_sel_q == SEL_CELL) ? KIND_VOLT : KIND_TEMP;
							left_q <= 3'd2;
							if (hdr_len_q > 8'd5) begin
								state_q <= ST_READ;
							end
						end else if (hdr_sel_q == SEL_CURR) begin
							kind_q  <= KIND_CURR;
							left_q  <= 3'd4;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					rd_addr_q <= rd_addr_q + 8'd1;
					left_q    <= left_q - 3'd1;
					if (left_q == 3'd1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					last_q <= (kind_q == KIND_CURR) ||
						({1'b0, pos_q} + 9'd3 >= {1'b0, hdr_len_q}) ||
						(n_q == LAST_RECORD_IDX);
					case (kind_q)
						KIND_TEMP: begin
							prod_q  <= 33'(sh_q[31:16]) * 33'(DIV100_MUL);
							state_q <= ST_DIV;
						end
						KIND_CURR: begin
							val_q   <= sh_q[31] ? (29'd0 - {1'b0, mag}) : {1'b0, mag};
							state_q <= ST_OUT;
						end
						default: begin
							val_q   <= 29'(sh_q[31:16]);
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_DIV: begin
					val_q   <= 29'(prod_q[32:DIV100_SHIFT]);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q     <= pos_q + 8'd2;
							rd_addr_q <= pos_q + 8'd2;
							n_q       <= n_q + 5'd1;
							left_q    <= 3'd2;
							state_q   <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/sensor_frame_deframer_decoder.sv
`timescale 1ns / 1ps
// After a frame's end word is taken, its decode request goes through the command queue
// (later when the queue still holds stored words) before the decoder starts its first record.
// Throughput: one word per cycle while storing and the queue has room; each record then takes
// two store reads (four for a current record), drain, compute, divide for temperature, output.
// Reset: arst_n clears the framing state, the queue and the decoder; the store keeps old data.
// ----------------------------------------------------------------------------
// Sensor frame deframer and decoder
// Finds framed sensor messages in a byte stream, checks length and XOR, and
// decodes cell voltage, temperature and current records from them.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_decoder import sfd_pkg::*; #(
	parameter int FRAME_BYTES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         record_kind,
	output logic [4:0]         record_index,
	output logic signed [28:0] record_value,
	output logic               last_record
);

	// The front end turns every accepted word into at most one command: a store
	// of a frame word at its slot, or a decode request once the end word and a
	// zero XOR have been seen. Words outside a frame produce no command.
	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;

	// The queue output feeds the decoder, which only pops while it is idle, so
	// stores of the next frame cannot overtake a decode in progress.
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;

	sfd_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	// A short queue lets the front end keep taking words while the decoder
	// is stalled on the output side, until the queue holds QUEUE_DEPTH commands.
	sfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	// The decoder owns the frame store. Records are held in output registers
	// until the consumer takes them.
	sfd_back #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (back_valid),
		.cmd_ready    (back_ready),
		.cmd          (back_cmd),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.record_kind  (record_kind),
		.record_index (record_index),
		.record_value (record_value),
		.last_record  (last_record)
	);

endmodule

>>> src/sfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame deframer port checker
// Watches the top-level ports for record stability and record consistency.
// ----------------------------------------------------------------------------
module sfd_checker import sfd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         record_kind,
	input logic [4:0]         record_index,
	input logic signed [28:0] record_value,
	input logic               last_record
);

	// A stalled record holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(record_value) &&
		$stable(record_index) && $stable(last_record))
		else $error("stalled record changed");

	// A current record is alone in its frame.
	a_curr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_CURR |-> last_record && record_index == 5'd0)
		else $error("current record not single");

	// Temperatures are a 16-bit value divided by 100.
	a_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == KIND_TEMP |->
		!record_value[28] && record_value <= 29'sd655)
		else $error("temperature out of range");

	// After a non-final record is taken, the next record continues the count.
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_record |=>
		!out_valid || record_index == $past(record_index) + 5'd1)
		else $error("record index skipped");

endmodule

bind sensor_frame_deframer_decoder sfd_checker u_sfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.record_kind  (record_kind),
	.record_index (record_index),
	.record_value (record_value),
	.last_record  (last_record)
);
